>>> src/sorted_top_n_score_table_assert.svh
// Assertion macros used by the sorted top-N score table RTL.
`ifndef SORTED_TOP_N_SCORE_TABLE_ASSERT_SVH
`define SORTED_TOP_N_SCORE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/stns_pkg.sv
// Types and codes shared by the sorted top-N score table.
package stns_pkg;

	typedef struct packed {
		logic        [15:0] tag;
		logic signed [31:0] score;
	} entry_t;

	typedef enum logic [2:0] {
		KIND_ENTER     = 3'd0,
		KIND_WRITE     = 3'd1,
		KIND_CLEAR     = 3'd2,
		KIND_CLEAR_ALL = 3'd3,
		KIND_READ      = 3'd4
	} kind_t;

	// Per-cycle command broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_RM_POS,
		CELL_RM_EMPTY,
		CELL_CLEAR_ALL,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [7:0] pos;
		entry_t     new_entry;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_INS
	} state_t;

endpackage

>>> src/stns_cell.sv
// One table cell: holds an entry, removes by shifting up, inserts by shifting down.
module stns_cell #(
	parameter int IDX  = 0,
	parameter bit LAST = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stns_pkg::cell_ctrl_t ctrl,
	input  stns_pkg::entry_t    prev_entry,
	input  stns_pkg::entry_t    next_entry,
	input  logic                found_in,
	input  logic                before_in,
	output logic                found_out,
	output logic                before_out,
	output stns_pkg::entry_t    entry,
	output stns_pkg::entry_t    entry_next
);
	import stns_pkg::*;

	entry_t entry_q;
	logic   after_q;
	logic   after_d;
	logic   empty;
	logic   rm;
	logic   gt;
	logic   eq;

	assign entry     = entry_q;
	assign empty     = (entry_q.tag == 16'd0) && (entry_q.score == 32'sd0);
	assign found_out = found_in | empty;

	assign gt = $signed(entry_q.score) > $signed(ctrl.new_entry.score);
	assign eq = entry_q.score == ctrl.new_entry.score;
	// after_q marks entries that sat below the removed one: ties put them after the new entry
	assign before_out = !LAST && (gt || (eq && !after_q));

	always_comb begin
		rm = 1'b0;
		case (ctrl.op)
			CELL_RM_POS:   rm = LAST || (9'(IDX) >= {1'b0, ctrl.pos});
			CELL_RM_EMPTY: rm = LAST || found_out;
			default:       rm = 1'b0;
		endcase
	end

	always_comb begin
		entry_next = entry_q;
		after_d    = after_q;
		case (ctrl.op) inside
			CELL_RM_POS, CELL_RM_EMPTY: begin
				after_d = rm;
				if (rm) begin
					entry_next = next_entry;
				end
			end
			CELL_CLEAR_ALL: begin
				entry_next = '0;
			end
			CELL_INSERT: begin
				if (!before_out) begin
					entry_next = before_in ? ctrl.new_entry : prev_entry;
				end
			end
			default: begin
				entry_next = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			after_q <= 1'b0;
		end else begin
			entry_q <= entry_next;
			after_q <= after_d;
		end
	end

endmodule

>>> src/sorted_top_n_score_table.sv
// Sorted top-N score table: input decode, cell chain, result register.
//
// Keeps ENTRIES (tag, score) pairs in descending signed score order; equal
// scores keep their relative order. Input transactions on the s_ channel carry
// an operation kind in s_tuser and position, tag and score in s_tdata. Every
// input transaction yields exactly one output transaction on the m_ channel:
// the accepted flag, the entry at the requested position and the head entry,
// all taken after the operation.
// An item takes two steps: the accepting edge removes the target entry from
// the row of cells (shift up) or clears the row; the insert step then inserts
// the new entry (shift down) and loads the result register, raising m_tvalid.
// A new item is taken only once the insert step of the last one is done.
// Finding the first empty entry ripples a flag down the cell row.
// Reset empties the table (all tags and scores zero) and the output channel.
// When the receiver stalls, the finished result waits in the output register
// and the next item stays in its insert step until the register frees up;
// s_tready stays low meanwhile.
module sorted_top_n_score_table #(
	parameter int ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // position[7:0], name_tag[23:8], score[55:24], zero pad
	input  logic [2:0]   s_tuser,   // kind[2:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // accepted[0], read_tag[16:1], read_score[48:17],
	                                // top_tag[64:49], top_score[96:65], zero pad
);
	import stns_pkg::*;

	localparam int IW = $clog2(ENTRIES);

	state_t     state_q;
	state_t     state_d;
	cell_ctrl_t ctrl;

	logic [7:0]  in_pos;
	entry_t      in_entry;
	kind_t       in_kind;
	logic        in_pos_ok;
	logic        accept;
	logic        advance;

	logic        ins_q;
	entry_t      new_q;
	logic [7:0]  pos_q;
	logic        pos_ok_q;
	logic        acc_q;
	logic        acc_d;

	entry_t      cell_q     [ENTRIES];
	entry_t      cell_d     [ENTRIES];
	entry_t      prev_in    [ENTRIES];
	entry_t      next_in    [ENTRIES];
	logic        found      [ENTRIES+1];
	logic        ahead      [ENTRIES+1];

	logic        m_tvalid_q;
	entry_t      rd_q;
	entry_t      top_q;
	logic        out_acc_q;
	entry_t      rd_d;

	assign in_pos         = s_tdata[7:0];
	assign in_entry.tag   = s_tdata[23:8];
	assign in_entry.score = s_tdata[55:24];
	assign in_kind        = kind_t'(s_tuser);
	assign in_pos_ok      = {1'b0, in_pos} < 9'(ENTRIES);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign advance  = (state_q == ST_INS) && (!m_tvalid_q || m_tready);

	always_comb begin
		unique case (in_kind) inside
			KIND_ENTER, KIND_CLEAR_ALL:        acc_d = 1'b1;
			KIND_WRITE, KIND_CLEAR, KIND_READ: acc_d = in_pos_ok;
			default:                           acc_d = 1'b0;
		endcase
	end

	always_comb begin
		state_d       = state_q;
		ctrl.op       = CELL_HOLD;
		ctrl.pos      = in_pos;
		ctrl.new_entry = new_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_INS;
					unique case (in_kind) inside
						KIND_ENTER:            ctrl.op = CELL_RM_EMPTY;
						KIND_WRITE, KIND_CLEAR: ctrl.op = in_pos_ok ? CELL_RM_POS : CELL_HOLD;
						KIND_CLEAR_ALL:        ctrl.op = CELL_CLEAR_ALL;
						default:               ctrl.op = CELL_HOLD;
					endcase
				end
			end
			ST_INS: begin
				if (advance) begin
					state_d = ST_IDLE;
					ctrl.op = ins_q ? CELL_INSERT : CELL_HOLD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ins_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				ins_q <= (in_kind == KIND_ENTER) ||
				         (((in_kind == KIND_WRITE) || (in_kind == KIND_CLEAR)) && in_pos_ok);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q    <= (in_kind == KIND_CLEAR) ? '0 : in_entry;
			pos_q    <= in_pos;
			pos_ok_q <= in_pos_ok;
			acc_q    <= acc_d;
		end
	end

	// Cell row
	assign found[0] = 1'b0;
	assign ahead[0] = 1'b1;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_in[i] = '0;
		end else begin : g_mid
			assign prev_in[i] = cell_q[i-1];
		end
		if (i == ENTRIES - 1) begin : g_last
			assign next_in[i] = '0;
		end else begin : g_inner
			assign next_in[i] = cell_q[i+1];
		end

		stns_cell #(
			.IDX  (i),
			.LAST (i == ENTRIES - 1)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry (prev_in[i]),
			.next_entry (next_in[i]),
			.found_in   (found[i]),
			.before_in  (ahead[i]),
			.found_out  (found[i+1]),
			.before_out (ahead[i+1]),
			.entry      (cell_q[i]),
			.entry_next (cell_d[i])
		);
	end

	// Result is taken from the table as it will be after the insert edge
	assign rd_d = pos_ok_q ? cell_d[pos_q[IW-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q      <= rd_d;
			top_q     <= cell_d[0];
			out_acc_q <= acc_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, top_q.score, top_q.tag, rd_q.score, rd_q.tag, out_acc_q};

`include "sorted_top_n_score_table_assert.svh"

	`STNS_ASSERT_NEXT(a_accept_to_insert, clk, arst_n, accept, state_q == ST_INS, "accepted item did not move to insert step")
	`STNS_ASSERT_NOW(a_head_sorted, clk, arst_n, 1'b1, $signed(cell_q[0].score) >= $signed(cell_q[1].score), "table head below second entry")
	`STNS_ASSERT_NEXT(a_result_loaded, clk, arst_n, advance, m_tvalid_q && (state_q == ST_IDLE), "insert step did not produce a result")

endmodule

>>> sim/sorted_top_n_score_table_tb.sv
// Self-checking testbench for the sorted top-N score table: directed and random stream traffic.
module sorted_top_n_score_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stns_pkg::*;

	localparam int NUM_ENTRIES = 16;
	localparam int RANDOM_ITEMS = 1250;
	localparam int PAUSE_AT_ITEM = 600;
	localparam int HOLD_AT_RESULT = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] KIND_UNDEF_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNDEF_LAST = 3'd7;
	localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

	typedef struct {
		logic              accepted;
		logic [15:0]       read_tag;
		logic signed [31:0] read_score;
		logic [15:0]       top_tag;
		logic signed [31:0] top_score;
	} table_result_t;

	// Mirror of the table contents plus the queue of results still owed by the block.
	class score_table_board;
		entry_t rows[NUM_ENTRIES];
		table_result_t owed_q[$];
		int errors;

		function new();
			errors = 0;
			clear_rows();
		endfunction

		function void clear_rows();
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				rows[i].tag = '0;
				rows[i].score = '0;
			end
		endfunction

		// Stable insertion sort, highest score first.
		function void resort();
			entry_t held;
			int j;
			for (int i = 1; i < NUM_ENTRIES; i++) begin
				held = rows[i];
				j = i;
				while (j > 0 && held.score > rows[j - 1].score) begin
					rows[j] = rows[j - 1];
					j--;
				end
				rows[j] = held;
			end
		endfunction

		function void note_input(logic [2:0] kind, logic [7:0] pos, logic [15:0] tag,
			logic signed [31:0] score);
			table_result_t res;
			int slot;
			logic in_range;
			in_range = pos < NUM_ENTRIES;
			res.accepted = 1'b0;
			case (kind)
				KIND_ENTER: begin
					// first empty row, else the bottom row
					slot = NUM_ENTRIES - 1;
					for (int i = NUM_ENTRIES - 1; i >= 0; i--)
						if (rows[i].tag == '0 && rows[i].score == '0)
							slot = i;
					rows[slot].tag = tag;
					rows[slot].score = score;
					resort();
					res.accepted = 1'b1;
				end
				KIND_WRITE: begin
					if (in_range) begin
						rows[pos].tag = tag;
						rows[pos].score = score;
						resort();
						res.accepted = 1'b1;
					end
				end
				KIND_CLEAR: begin
					if (in_range) begin
						rows[pos].tag = '0;
						rows[pos].score = '0;
						resort();
						res.accepted = 1'b1;
					end
				end
				KIND_CLEAR_ALL: begin
					clear_rows();
					res.accepted = 1'b1;
				end
				KIND_READ: res.accepted = in_range;
				default: ;
			endcase
			if (in_range) begin
				res.read_tag = rows[pos].tag;
				res.read_score = rows[pos].score;
			end else begin
				res.read_tag = '0;
				res.read_score = '0;
			end
			res.top_tag = rows[0].tag;
			res.top_score = rows[0].score;
			owed_q.push_back(res);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: mismatch on %s: expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [103:0] word);
			table_result_t want;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected result transaction: expected none, actual %h",
					$time, word);
				errors++;
			end else begin
				want = owed_q.pop_front();
				compare_field("accepted", 32'(want.accepted), 32'(word[0]));
				compare_field("read_tag", 32'(want.read_tag), 32'(word[16:1]));
				compare_field("read_score", want.read_score, word[48:17]);
				compare_field("top_tag", 32'(want.top_tag), 32'(word[64:49]));
				compare_field("top_score", want.top_score, word[96:65]);
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;

	score_table_board sb = new();
	int items_sent;
	int cycles;

	sorted_top_n_score_table #(
		.ENTRIES(NUM_ENTRIES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Transaction monitor: both channels sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[55:24]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// Receiver: random stall per result, quiet stretches, and one long hold-off.
	initial begin
		int gap;
		int got;
		m_tready = 1'b0;
		got = 0;
		@(posedge arst_n);
		forever begin
			if ((got / 100) % 4 == 3)
				gap = 0;
			else
				gap = $urandom_range(0, 13);
			if (got == HOLD_AT_RESULT)
				gap = HOLD_CYCLES;
			repeat (gap) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got++;
		end
	end

	task automatic send_item(logic [2:0] kind, logic [7:0] pos, logic [15:0] tag,
		logic signed [31:0] score);
		int gap;
		if ((items_sent / 150) % 3 == 2)
			gap = 0;
		else
			gap = $urandom_range(0, 13);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {8'h00, score, tag, pos};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_random_item();
		logic [2:0] kind;
		logic [7:0] pos;
		logic [15:0] tag;
		logic signed [31:0] score;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 47)
			kind = KIND_ENTER;
		else if (pick < 62)
			kind = KIND_WRITE;
		else if (pick < 68)
			kind = KIND_CLEAR;
		else if (pick < 69)
			kind = KIND_CLEAR_ALL;
		else if (pick < 96)
			kind = KIND_READ;
		else
			kind = 3'($urandom_range(KIND_UNDEF_FIRST, KIND_UNDEF_LAST));
		if ($urandom_range(0, 9) == 0)
			pos = 8'($urandom_range(0, 255));
		else
			pos = 8'($urandom_range(0, NUM_ENTRIES - 1));
		tag = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom());
		// small scores make ties common; zero with tag zero makes empty rows
		case ($urandom_range(0, 5)) inside
			0, 1: score = $urandom();
			2, 3: score = $signed(32'($urandom_range(0, 20))) - 32'sd10;
			4: score = $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
			default: score = '0;
		endcase
		send_item(kind, pos, tag, score);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_ENTER;
		items_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part: reads of an empty table and out-of-range positions
		send_item(KIND_READ, 8'd0, 16'h0000, '0);
		send_item(KIND_READ, 8'(NUM_ENTRIES - 1), 16'h0000, '0);
		send_item(KIND_READ, 8'(NUM_ENTRIES), 16'h0000, '0);
		send_item(KIND_READ, 8'hFF, 16'h0000, '0);
		// score extremes, zero tag with a score, zero score with a tag, ties
		send_item(KIND_ENTER, 8'hFF, 16'hFFFF, SCORE_MAX);
		send_item(KIND_ENTER, 8'd0, 16'h0001, SCORE_MIN);
		send_item(KIND_ENTER, 8'd0, 16'h0000, 32'sd5);
		send_item(KIND_ENTER, 8'd0, 16'h0002, 32'sd0);
		send_item(KIND_ENTER, 8'd0, 16'h0003, 32'sd0);
		send_item(KIND_ENTER, 8'd0, 16'h0004, 32'sd5);
		send_item(KIND_WRITE, 8'(NUM_ENTRIES - 1), 16'h0007, -32'sd1);
		send_item(KIND_WRITE, 8'(NUM_ENTRIES), 16'h0008, 32'sd9);
		send_item(KIND_WRITE, 8'd2, 16'h0000, 32'sd0);
		send_item(KIND_CLEAR, 8'd1, 16'h0000, '0);
		send_item(KIND_CLEAR, 8'hFF, 16'h0000, '0);
		send_item(KIND_UNDEF_FIRST, 8'd0, 16'h1234, 32'sd77);
		send_item(3'd6, 8'd200, 16'h0000, '0);
		send_item(KIND_UNDEF_LAST, 8'd3, 16'hAAAA, SCORE_MAX);
		send_item(KIND_READ, 8'd3, 16'h0000, '0);
		send_item(KIND_CLEAR_ALL, 8'hFF, 16'hFFFF, SCORE_MIN);
		send_item(KIND_READ, 8'd0, 16'h0000, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PAUSE_AT_ITEM) begin
				// let the block drain completely before going on
				@(negedge clk);
				s_tvalid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			send_random_item();
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
